/* hdl/stb_pkg.sv */
// Package for the software timer bank: action codes, register indexes,
// lane command struct and reset defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stb_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  localparam logic [2:0] CFG_PERIODIC = 3'd0;
  localparam logic [2:0] CFG_RELOAD0  = 3'd1;

  localparam int          MAX_REG_TIMERS   = 4;
  localparam logic [3:0]  PERIODIC_DEFAULT = 4'd15;
  localparam int          RUNNING_DEFAULT  = 3;

  typedef struct packed {
    logic tick;
    logic start;
    logic clear;
  } lane_cmd_t;

  function automatic logic [63:0] reload_default(input int idx);
    logic [63:0] val;
    case (idx)
      0:       val = 64'd1000;
      1:       val = 64'd2000;
      2:       val = 64'd2000;
      3:       val = 64'd10000;
      default: val = 64'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

/* hdl/stb_lane.sv */
// One down-counting timer: count, running bit and sticky event flag.
// Depends on stb_pkg for the lane command struct and reset defaults.
`timescale 1ns / 1ps
`default_nettype none
module stb_lane #(
  parameter int LANE_INDEX  = 0,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  stb_pkg::lane_cmd_t     cmd,
  input  wire [COUNT_WIDTH-1:0]  load_count,
  input  wire [COUNT_WIDTH-1:0]  reload_count,
  input  wire                    periodic,
  output logic                   expired,
  output logic                   event_flag
);
  import stb_pkg::*;

  localparam logic [63:0] RESET_EXT = reload_default(LANE_INDEX);
  localparam logic [COUNT_WIDTH-1:0] RESET_COUNT = RESET_EXT[COUNT_WIDTH-1:0];
  localparam logic RESET_RUN = (LANE_INDEX == RUNNING_DEFAULT);

  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_dec;
  logic                   running_r, running_nxt;
  logic                   event_r, event_nxt;

  assign count_dec = count_r - COUNT_WIDTH'(1);

  always_comb begin
    count_nxt   = count_r;
    running_nxt = running_r;
    event_nxt   = event_r;
    expired     = 1'b0;
    if (cmd.tick) begin
      if (running_r && (count_r != '0)) begin
        if (count_dec == '0) begin
          expired   = 1'b1;
          event_nxt = 1'b1;
          count_nxt = reload_count;
          if (!periodic) begin
            running_nxt = 1'b0;
          end
        end else begin
          count_nxt = count_dec;
        end
      end
    end else if (cmd.start) begin
      running_nxt = 1'b1;
      count_nxt   = load_count;
      event_nxt   = 1'b0;
    end else if (cmd.clear) begin
      event_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= RESET_COUNT;
      running_r <= RESET_RUN;
      event_r   <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      running_r <= running_nxt;
      event_r   <= event_nxt;
    end
  end

  assign event_flag = event_r;

endmodule
`default_nettype wire

/* hdl/software_timer_bank_core.sv */
// Top level of the software timer bank: input register, timer lanes,
// tick counter, configuration registers and result register.
// Depends on stb_pkg and stb_lane.
//
// Usage:
//   in_*   : one beat per action. in_tuser = {timer_index, action},
//            in_tdata = load_count. Actions: tick, start, clear, query.
//   out_*  : one beat per input beat, in order. out_tdata holds
//            expired_mask, event_state and tick_count after the action.
//   cfg_*  : register writes (0 periodic mask, 1..4 reload counts); always
//            ready, write only while the block is idle.
// Path: an input beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_tready holds; all lanes take the
// command in parallel in the cycle the item leaves the input register.
// Reset: synchronous, active low; counts take their default reloads, only
// timer 3 runs, events and the tick counter clear, both stages empty.
// Stall: a held result keeps its beat; one more item waits in the input
// register, after which in_tready drops until out_tready returns.
`timescale 1ns / 1ps
`default_nettype none
module software_timer_bank_core #(
  parameter int NUM_TIMERS  = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] load_count
  input  wire  [3:0]  in_tuser,   // [1:0] action, [3:2] timer_index
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [3:0] expired_mask, [4] event_state,
                                  // [36:5] tick_count, [39:37] zero
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import stb_pkg::*;

  localparam logic [NUM_TIMERS-1:0] PERIODIC_RESET =
    NUM_TIMERS'({12'd0, PERIODIC_DEFAULT});

  logic        s1_valid_r;
  action_t     s1_action_r;
  logic [1:0]  s1_idx_r;
  logic [31:0] s1_load_r;
  logic        advance;

  logic [NUM_TIMERS-1:0] periodic_r;
  logic [NUM_TIMERS-1:0] expired;
  logic [NUM_TIMERS-1:0] event_flags;
  logic [3:0]            expired4, event4;

  logic [31:0] ticks_r, ticks_nxt;
  logic        out_valid_r;
  logic [3:0]  out_exp_r;
  logic        out_ev_r, ev_sel;
  logic [31:0] out_ticks_r;

  logic [63:0]            load_ext, cfg_ext;
  logic [COUNT_WIDTH-1:0] load_cw, cfg_cw;

  assign load_ext = {32'd0, s1_load_r};
  assign cfg_ext  = {32'd0, cfg_data};
  assign load_cw  = load_ext[COUNT_WIDTH-1:0];
  assign cfg_cw   = cfg_ext[COUNT_WIDTH-1:0];

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= action_t'(in_tuser[1:0]);
      s1_idx_r    <= in_tuser[3:2];
      s1_load_r   <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periodic_r <= PERIODIC_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index == CFG_PERIODIC)) begin
      periodic_r <= NUM_TIMERS'({12'd0, cfg_data[3:0]});
    end
  end

  genvar k;
  generate
    for (k = 0; k < NUM_TIMERS; k++) begin : g_lane
      localparam logic [3:0] LANE_ID = 4'(k);
      lane_cmd_t              cmd;
      logic                   hit;
      logic [COUNT_WIDTH-1:0] reload;

      assign hit       = ({2'b00, s1_idx_r} == LANE_ID);
      assign cmd.tick  = advance && (s1_action_r == ACT_TICK);
      assign cmd.start = advance && (s1_action_r == ACT_START) && hit;
      assign cmd.clear = advance && (s1_action_r == ACT_CLEAR) && hit;

      if (k < MAX_REG_TIMERS) begin : g_reload
        localparam logic [2:0] REG_ID = CFG_RELOAD0 + 3'(k);
        localparam logic [63:0] RELOAD_EXT = reload_default(k);
        logic [COUNT_WIDTH-1:0] reload_r;
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            reload_r <= RELOAD_EXT[COUNT_WIDTH-1:0];
          end else if (cfg_valid && cfg_ready && (cfg_index == REG_ID)) begin
            reload_r <= cfg_cw;
          end
        end
        assign reload = reload_r;
      end else begin : g_noreload
        assign reload = '0;
      end

      stb_lane #(
        .LANE_INDEX  (k),
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .load_count   (load_cw),
        .reload_count (reload),
        .periodic     (periodic_r[k]),
        .expired      (expired[k]),
        .event_flag   (event_flags[k])
      );
    end

    for (k = 0; k < 4; k++) begin : g_pad
      if (k < NUM_TIMERS) begin : g_on
        assign expired4[k] = expired[k];
        assign event4[k]   = event_flags[k];
      end else begin : g_off
        assign expired4[k] = 1'b0;
        assign event4[k]   = 1'b0;
      end
    end
  endgenerate

  assign ticks_nxt = (s1_action_r == ACT_TICK) ? ticks_r + 32'd1 : ticks_r;
  assign ev_sel    = (s1_action_r == ACT_QUERY) ? event4[s1_idx_r] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= 32'd0;
    end else if (advance) begin
      ticks_r <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_exp_r   <= expired4;
      out_ev_r    <= ev_sel;
      out_ticks_r <= ticks_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_ticks_r, out_ev_r, out_exp_r};

endmodule
`default_nettype wire

/* hdl/stb_checker.sv */
// Port-level checks for the software timer bank, bound to the top level.
// Depends only on the ports of software_timer_bank_core.
`timescale 1ns / 1ps
`default_nettype none
module stb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  a_tick_or_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !((out_tdata[3:0] != 4'd0) && out_tdata[4]))
    else $error("expiry and event state in one beat");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind software_timer_bank_core stb_checker u_stb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
